FILE: hdl/pfba_pkg.sv
// Shared types and constants for the page frame bitmap allocator.
// Used by pfba_map_ram and page_frame_bitmap_allocator_core.
package pfba_pkg;

  localparam int unsigned DEF_MAP_BYTES   = 512;
  localparam int unsigned DEF_FRAME_BYTES = 4096;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned FADDR_W  = 24;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MAP_DW   = 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUPPLY = 2'd0,
    MODE_ALLOC  = 2'd1,
    MODE_FREE   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE    = 2'd0,
    STATUS_OOM     = 2'd1,
    STATUS_OUTSIDE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_BOUND,
    ST_FILL,
    ST_SCAN
  } state_e;

endpackage

FILE: hdl/page_frame_bitmap_allocator_core.sv
// Page frame bitmap allocator: sequencer, range bounds and bitmap update.
// Depends on pfba_pkg and pfba_map_ram.
//
// One free bit per frame of FRAME_BYTES bytes (a power of two) over MAP_BYTES*8
// frames from address zero. A command is taken when start is high and busy is
// low; exactly one result follows, shown on frame_address_o and status_o for
// the single cycle in which done_o is high, and it must be captured then.
// All work goes through one byte-wide bitmap memory, one byte per cycle:
// clear zeroes every map byte, allocate scans upward from the lowest byte,
// supply and free read and rewrite each touched map byte, and an empty or
// rejected supply or a rejected free touches no map byte. After reset the
// bitmap is swept to zero with busy high and no result.
module page_frame_bitmap_allocator_core #(
  parameter int unsigned MAP_BYTES   = pfba_pkg::DEF_MAP_BYTES,
  parameter int unsigned FRAME_BYTES = pfba_pkg::DEF_FRAME_BYTES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [pfba_pkg::MODE_W-1:0]   mode_i,
  input  logic [pfba_pkg::ADDR_W-1:0]   address_i,
  input  logic [pfba_pkg::LEN_W-1:0]    length_i,
  output logic                          done_o,
  output logic [pfba_pkg::FADDR_W-1:0]  frame_address_o,
  output logic [pfba_pkg::STATUS_W-1:0] status_o
);
  import pfba_pkg::*;

  localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
  localparam int unsigned FRAME_COUNT = MAP_BYTES * 8;
  localparam int unsigned MAP_AW      = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
  localparam int unsigned PW          = MAP_AW + 1;
  localparam int unsigned FIDX_W      = MAP_AW + 4;
  localparam int unsigned WIDE_W      = ADDR_W + 2;
  localparam int unsigned FA_W        = MAP_AW + 3 + FRAME_SHIFT;
  localparam logic [ADDR_W-1:0] OFF_MASK = ADDR_W'(FRAME_BYTES - 1);

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  logic [ADDR_W-1:0]   address_q, address_d;
  logic [LEN_W-1:0]    length_q, length_d;
  logic [WIDE_W-1:0]   first_q, first_d;
  logic [WIDE_W-1:0]   last_q, last_d;
  logic [FIDX_W-1:0]   lo_q, lo_d;
  logic [FIDX_W-1:0]   hi_q, hi_d;
  logic [PW-1:0]       ptr_q, ptr_d;
  logic                pend_q, pend_d;
  logic [MAP_AW-1:0]   pend_addr_q, pend_addr_d;
  logic                report_q, report_d;
  logic                done_q, done_d;
  logic [FADDR_W-1:0]  frame_address_q, frame_address_d;
  logic [STATUS_W-1:0] status_q, status_d;

  logic                we;
  logic [MAP_AW-1:0]   waddr;
  logic [MAP_DW-1:0]   wdata;
  logic                re;
  logic [MAP_AW-1:0]   raddr;
  logic [MAP_DW-1:0]   rdata;

  logic [WIDE_W-1:0]   addr_frame;
  logic                rem_nz;
  logic [ADDR_W:0]     slack;
  logic [WIDE_W-1:0]   sum;
  logic [WIDE_W-1:0]   hi_wide;
  logic [FIDX_W-1:0]   bit_f;
  logic [MAP_DW-1:0]   fill_mask;
  logic [MAP_DW-1:0]   low_bit;
  logic [2:0]          low_idx;
  logic [FA_W-1:0]     fa_wide;
  logic                can_issue;

  pfba_map_ram #(
    .DEPTH (MAP_BYTES),
    .AW    (MAP_AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    addr_frame = WIDE_W'(address_q >> FRAME_SHIFT);
    rem_nz     = |(address_q & OFF_MASK);
    slack      = (ADDR_W + 1)'(FRAME_BYTES) - (ADDR_W + 1)'(address_q & OFF_MASK);
    sum        = WIDE_W'(address_q) + WIDE_W'(length_q);
    hi_wide    = (last_q > WIDE_W'(FRAME_COUNT)) ? WIDE_W'(FRAME_COUNT) : last_q;
  end

  always_comb begin
    fill_mask = '0;
    bit_f     = '0;
    for (int x = 0; x < MAP_DW; x++) begin
      bit_f        = FIDX_W'({pend_addr_q, 3'(x)});
      fill_mask[x] = (bit_f >= lo_q) && (bit_f < hi_q);
    end
  end

  always_comb begin
    low_bit = rdata & (~rdata + MAP_DW'(1));
    low_idx = '0;
    for (int x = MAP_DW - 1; x >= 0; x--) begin
      if (rdata[x]) begin
        low_idx = 3'(x);
      end
    end
    fa_wide = FA_W'({pend_addr_q, low_idx}) << FRAME_SHIFT;
  end

  always_comb begin
    state_d         = state_q;
    mode_d          = mode_q;
    address_d       = address_q;
    length_d        = length_q;
    first_d         = first_q;
    last_d          = last_q;
    lo_d            = lo_q;
    hi_d            = hi_q;
    ptr_d           = ptr_q;
    pend_d          = 1'b0;
    pend_addr_d     = pend_addr_q;
    report_d        = report_q;
    done_d          = 1'b0;
    frame_address_d = frame_address_q;
    status_d        = status_q;
    we              = 1'b0;
    waddr           = pend_addr_q;
    wdata           = '0;
    re              = 1'b0;
    raddr           = ptr_q[MAP_AW-1:0];
    can_issue       = 1'b0;

    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = ptr_q[MAP_AW-1:0];
        wdata = '0;
        ptr_d = ptr_q + PW'(1);
        if (ptr_q == PW'(MAP_BYTES - 1)) begin
          state_d = ST_IDLE;
          if (report_q) begin
            done_d          = 1'b1;
            frame_address_d = '0;
            status_d        = STATUS_DONE;
          end
          report_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (start) begin
          mode_d    = mode_e'(mode_i);
          address_d = address_i;
          length_d  = length_i;
          ptr_d     = '0;
          unique case (mode_e'(mode_i))
            MODE_ALLOC: state_d = ST_SCAN;
            MODE_CLEAR: begin
              state_d  = ST_CLEAR;
              report_d = 1'b1;
            end
            MODE_SUPPLY, MODE_FREE: state_d = ST_PREP;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_PREP: begin
        state_d = ST_BOUND;
        if (mode_q == MODE_SUPPLY) begin
          first_d = addr_frame + WIDE_W'(rem_nz);
          if (rem_nz && ((ADDR_W + 1)'(length_q) < slack)) begin
            last_d = addr_frame + WIDE_W'(rem_nz);
          end else begin
            last_d = sum >> FRAME_SHIFT;
          end
        end else begin
          first_d = addr_frame;
          last_d  = addr_frame + WIDE_W'(1);
        end
      end
      ST_BOUND: begin
        lo_d  = FIDX_W'(first_q);
        hi_d  = FIDX_W'(hi_wide);
        ptr_d = PW'(first_q >> 3);
        if (first_q >= WIDE_W'(FRAME_COUNT)) begin
          state_d         = ST_IDLE;
          done_d          = 1'b1;
          frame_address_d = '0;
          status_d        = STATUS_OUTSIDE;
        end else if (first_q >= hi_wide) begin
          state_d         = ST_IDLE;
          done_d          = 1'b1;
          frame_address_d = '0;
          status_d        = STATUS_DONE;
        end else begin
          state_d = ST_FILL;
        end
      end
      ST_FILL: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = pend_addr_q;
          wdata = rdata | fill_mask;
        end
        can_issue = ({ptr_q, 3'b000} < hi_q);
        if (can_issue) begin
          re          = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[MAP_AW-1:0];
          ptr_d       = ptr_q + PW'(1);
        end else begin
          state_d         = ST_IDLE;
          done_d          = 1'b1;
          frame_address_d = '0;
          status_d        = STATUS_DONE;
        end
      end
      ST_SCAN: begin
        can_issue = (ptr_q < PW'(MAP_BYTES));
        if (pend_q && (rdata != '0)) begin
          we              = 1'b1;
          waddr           = pend_addr_q;
          wdata           = rdata & ~low_bit;
          state_d         = ST_IDLE;
          done_d          = 1'b1;
          frame_address_d = FADDR_W'(fa_wide);
          status_d        = STATUS_DONE;
        end else if (can_issue) begin
          re          = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[MAP_AW-1:0];
          ptr_d       = ptr_q + PW'(1);
        end else begin
          state_d         = ST_IDLE;
          done_d          = 1'b1;
          frame_address_d = '0;
          status_d        = STATUS_OOM;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      report_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      report_q <= report_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q          <= mode_d;
    address_q       <= address_d;
    length_q        <= length_d;
    first_q         <= first_d;
    last_q          <= last_d;
    lo_q            <= lo_d;
    hi_q            <= hi_d;
    pend_addr_q     <= pend_addr_d;
    frame_address_q <= frame_address_d;
    status_q        <= status_d;
  end

  assign busy            = (state_q != ST_IDLE);
  assign done_o          = done_q;
  assign frame_address_o = frame_address_q;
  assign status_o        = status_q;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result shown while sequencer is not idle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_oom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && (status_q == STATUS_OOM)) |-> (frame_address_q == '0))
    else $error("out of memory with nonzero frame address");

  a_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> ((state_q == ST_FILL) || (state_q == ST_SCAN)))
    else $error("read in flight outside fill or scan");
`endif

endmodule

FILE: hdl/pfba_map_ram.sv
// Free-frame bitmap storage: one write port, one registered read port.
// Depends on pfba_pkg for the entry width.
module pfba_map_ram #(
  parameter int unsigned DEPTH = pfba_pkg::DEF_MAP_BYTES,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [pfba_pkg::MAP_DW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [pfba_pkg::MAP_DW-1:0] rdata_o
);
  import pfba_pkg::*;

  logic [MAP_DW-1:0] mem_q [DEPTH];
  logic [MAP_DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
